@@ hw/rtl/nows_pkg.sv @@
// Shared types and constants for the nearest-obstacle wall steering unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nows_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd4;

    localparam logic signed [15:0] START_ANGLE_RST = -16'sd18000;
    localparam logic [11:0]        ANGLE_STEP_RST  = 12'd35;
    localparam logic [15:0]        MAX_RANGE_RST   = 16'd3500;
    localparam logic [13:0]        TARGET_GAP_RST  = 14'd400;
    localparam logic [6:0]         GAIN_RST        = 7'd20;

    localparam logic [15:0] NO_RETURN = 16'hFFFF;

    localparam int FULL_TURN_CDEG    = 36000;
    localparam int QUARTER_TURN_CDEG = 9000;
    localparam int IDX_ROUND         = 4500;

    // beam angle product width (12-bit step times index up to 4095)
    localparam int PROD_W = 24;

    // exact floor division by reciprocal: floor(x / d) = (x * R) >> S
    localparam logic [24:0] ANGLE_RECIP = 25'd30541990;   // 2^40 / 36000, rounded up
    localparam int          ANGLE_SHIFT = 40;
    localparam logic [25:0] SINE_RECIP  = 26'd61083980;   // 2^39 / 9000, rounded up
    localparam int          SINE_SHIFT  = 39;
    localparam logic [23:0] TENTH_RECIP = 24'd13421773;   // 2^27 / 10, rounded up
    localparam int          TENTH_SHIFT = 27;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [20:0] TURN_MAX = 21'sd524287;
    localparam logic signed [20:0] TURN_MIN = -21'sd524288;

    typedef struct packed {
        logic signed [15:0] start_angle_cdeg;
        logic [11:0]        angle_step_cdeg;
        logic [15:0]        max_range_mm;
        logic [13:0]        target_gap_mm;
        logic [6:0]         gain_tenths;
    } nows_cfg_t;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        last;
    } nows_in_t;

    typedef struct packed {
        logic signed [19:0] turn_rate_mrad_s;
        logic [15:0]        nearest_mm;
        logic signed [15:0] nearest_angle_cdeg;
        logic               obstacle_seen;
    } nows_out_t;

    // one sample with its wrapped beam angle
    typedef struct packed {
        logic [15:0]        range_mm;
        logic               last;
        logic signed [15:0] angle_cdeg;
    } nows_beam_t;

    // nearest return of a finished scan
    typedef struct packed {
        logic [15:0]        range_mm;
        logic signed [15:0] angle_cdeg;
    } nows_scan_t;

endpackage

@@ hw/rtl/nearest_obstacle_wall_steering_unit.sv @@
// Top level of the nearest-obstacle wall steering unit: configuration
// registers, nearest-return tracking, angle and steering pipelines. Uses nows_pkg.
`timescale 1ns / 1ps

// Takes one laser range sample per cycle while sample stall is low. Each sample's
// beam angle is built in a four-stage pipeline (start + step * index, folded into one
// turn), after which the sample is compared against the nearest return so far. The
// final sample of a scan hands the nearest return to a six-stage steering pipeline
// (sine lookup, gain, divide by ten, saturation) and clears the scan state in the same
// cycle, so the next scan can start on the following cycle. Sample stall rises only
// when a final sample meets a full steering pipeline, which holds up to six results.
// The sine table is built at elaboration and needs no fill after reset.

module nearest_obstacle_wall_steering_unit
    import nows_pkg::*;
#(
    parameter int MAX_BEAMS        = 1024,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  nows_in_t              sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output nows_out_t             result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    nows_cfg_t  cfg_reg, cfg_next;

    logic       sample_ready;
    logic       beam_valid;
    nows_beam_t beam;
    logic       beam_ready;
    logic       steer_ready;
    logic       beam_fire;
    logic       closer;
    nows_scan_t scan;

    logic [15:0]        best_range_reg, best_range_next;
    logic signed [15:0] best_angle_reg, best_angle_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_ANGLE: cfg_next.start_angle_cdeg = $signed(cfg_data[15:0]);
                CFG_ANGLE_STEP:  cfg_next.angle_step_cdeg  = cfg_data[11:0];
                CFG_MAX_RANGE:   cfg_next.max_range_mm     = cfg_data[15:0];
                CFG_TARGET_GAP:  cfg_next.target_gap_mm    = cfg_data[13:0];
                CFG_GAIN:        cfg_next.gain_tenths      = cfg_data[6:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    nows_angle_pipe #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_angle_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample_valid),
        .in_data   (sample),
        .in_ready  (sample_ready),
        .out_valid (beam_valid),
        .out_data  (beam),
        .out_ready (beam_ready)
    );

    assign sample_stall = !sample_ready;

    // non-final samples only touch the scan state and never wait
    assign beam_ready = !beam.last || steer_ready;
    assign beam_fire  = beam_valid && beam_ready;
    assign closer     = beam.range_mm < best_range_reg;

    always_comb
    begin
        scan.range_mm   = closer ? beam.range_mm   : best_range_reg;
        scan.angle_cdeg = closer ? beam.angle_cdeg : best_angle_reg;
        if (beam.last)
        begin
            best_range_next = NO_RETURN;
            best_angle_next = '0;
        end
        else
        begin
            best_range_next = scan.range_mm;
            best_angle_next = scan.angle_cdeg;
        end
    end

    nows_steer_pipe #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_steer_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (beam_valid && beam.last),
        .in_data   (scan),
        .in_ready  (steer_ready),
        .out_valid (result_valid),
        .out_data  (result),
        .out_ready (!result_stall)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle_cdeg <= START_ANGLE_RST;
            cfg_reg.angle_step_cdeg  <= ANGLE_STEP_RST;
            cfg_reg.max_range_mm     <= MAX_RANGE_RST;
            cfg_reg.target_gap_mm    <= TARGET_GAP_RST;
            cfg_reg.gain_tenths      <= GAIN_RST;
            best_range_reg           <= NO_RETURN;
            best_angle_reg           <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (beam_fire)
            begin
                best_range_reg <= best_range_next;
                best_angle_reg <= best_angle_next;
            end
        end
    end

endmodule

@@ hw/rtl/nows_sine_rom.sv @@
// Quarter-wave sine table, 1000*sin in steps of 90/(DEPTH-1) degrees.
// Entries are built at elaboration; read is registered. Uses nows_pkg.
`timescale 1ns / 1ps

module nows_sine_rom
    import nows_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [9:0]               data
);

    logic [9:0] sine_lut [DEPTH];
    logic [9:0] data_reg;

    // Q30 Taylor series up to x^15, truncating each term
    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(i)) / 64'(DEPTH - 1);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
        localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
        localparam logic [63:0] S  = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
        localparam logic [63:0] V  = (S * 64'd1000 + (64'd1 << 29)) >> 30;
        assign sine_lut[i] = V[9:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= sine_lut[addr];
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/nows_angle_pipe.sv @@
// Beam index counter and four-stage beam angle pipeline:
// step*index, reciprocal quotient, remainder mod 360 deg, offset and wrap. Uses nows_pkg.
`timescale 1ns / 1ps

module nows_angle_pipe
    import nows_pkg::*;
#(
    parameter int MAX_BEAMS = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  nows_cfg_t  cfg,
    input  logic       in_valid,
    input  nows_in_t   in_data,
    output logic       in_ready,
    output logic       out_valid,
    output nows_beam_t out_data,
    input  logic       out_ready
);

    localparam int IDX_W = $clog2(MAX_BEAMS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BEAMS - 1);

    localparam logic signed [17:0] WRAP_LO  = -18'sd18000;
    localparam logic signed [17:0] WRAP_HI  = 18'sd18000;
    localparam logic signed [17:0] WRAP_HI2 = 18'sd54000;
    localparam logic signed [17:0] ONE_TURN = 18'sd36000;
    localparam logic signed [17:0] TWO_TURN = 18'sd72000;

    logic [IDX_W-1:0] index_reg, index_next;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              rdy1, rdy2, rdy3, rdy4;
    nows_in_t          s1_reg, s2_reg, s3_reg;
    logic [PROD_W-1:0] prod1_reg, prod1_next;
    logic [PROD_W-1:0] prod2_reg;
    logic [8:0]        quot2_reg, quot2_next;
    logic [15:0]       rem3_reg, rem3_next;
    nows_beam_t        beam4_reg, beam4_next;

    logic [PROD_W+24:0]   quot_mult;
    logic signed [17:0]   raw_angle;
    logic signed [17:0]   wrapped;
    logic                 accept;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign accept   = in_valid && rdy1;

    always_comb
    begin
        index_next = index_reg;
        if (in_data.last)
        begin
            index_next = '0;
        end
        else if (index_reg < LAST_IDX)
        begin
            index_next = index_reg + 1'b1;
        end
    end

    always_comb
    begin
        prod1_next = PROD_W'(cfg.angle_step_cdeg) * PROD_W'(index_reg);
        quot_mult  = (PROD_W + 25)'(prod1_reg) * (PROD_W + 25)'(ANGLE_RECIP);
        quot2_next = quot_mult[ANGLE_SHIFT +: 9];
        rem3_next  = 16'(prod2_reg - PROD_W'(quot2_reg) * PROD_W'(FULL_TURN_CDEG));
    end

    // start + remainder lies in [-32768, 68766]; fold into [-18000, 17999]
    always_comb
    begin
        raw_angle = 18'(cfg.start_angle_cdeg) + $signed({2'b00, rem3_reg});
        if (raw_angle < WRAP_LO)
        begin
            wrapped = raw_angle + ONE_TURN;
        end
        else if (raw_angle >= WRAP_HI2)
        begin
            wrapped = raw_angle - TWO_TURN;
        end
        else if (raw_angle >= WRAP_HI)
        begin
            wrapped = raw_angle - ONE_TURN;
        end
        else
        begin
            wrapped = raw_angle;
        end
        beam4_next.range_mm   = s3_reg.range_mm;
        beam4_next.last       = s3_reg.last;
        beam4_next.angle_cdeg = 16'(wrapped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                index_reg <= index_next;
            end
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg    <= in_data;
            prod1_reg <= prod1_next;
        end
        if (v1_reg && rdy2)
        begin
            s2_reg    <= s1_reg;
            prod2_reg <= prod1_reg;
            quot2_reg <= quot2_next;
        end
        if (v2_reg && rdy3)
        begin
            s3_reg   <= s2_reg;
            rem3_reg <= rem3_next;
        end
        if (v3_reg && rdy4)
        begin
            beam4_reg <= beam4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = beam4_reg;

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_data.last && index_reg < LAST_IDX |=> index_reg == $past(index_reg) + 1'b1)
        else $error("beam index did not advance");

    a_index_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last |=> index_reg == '0)
        else $error("beam index not cleared after final sample");

    a_angle_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> rem3_reg < 16'(FULL_TURN_CDEG))
        else $error("angle remainder out of range");

endmodule

@@ hw/rtl/nows_steer_pipe.sv @@
// Steering pipeline for one finished scan: sine index, table read, gain
// multiply, divide by ten, saturate. Uses nows_pkg and nows_sine_rom.
`timescale 1ns / 1ps

module nows_steer_pipe
    import nows_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  nows_cfg_t  cfg,
    input  logic       in_valid,
    input  nows_scan_t in_data,
    output logic       in_ready,
    output logic       out_valid,
    output nows_out_t  out_data,
    input  logic       out_ready
);

    localparam int SIN_IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam logic [11:0] LAST_ENTRY = 12'(SINE_TABLE_DEPTH - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    nows_scan_t scan1_reg, scan2_reg, scan3_reg, scan4_reg, scan5_reg;
    logic       seen1_reg, seen2_reg, seen3_reg, seen4_reg, seen5_reg;
    logic       neg1_reg, neg2_reg, neg3_reg;
    logic [25:0] m1_reg, m1_next;
    logic [SIN_IDX_W-1:0] idx2_reg, idx2_next;
    logic [9:0]  sine3;
    logic signed [24:0] prod4_reg, prod4_next;
    logic [19:0] q5_reg, q5_next;
    logic        neg5_reg;
    nows_out_t   out6_reg, out6_next;

    logic [15:0] mag;
    logic        alpha_neg;
    logic [13:0] abs_alpha;
    logic        seen_next;
    logic [51:0] idx_mult;
    logic [11:0] idx_raw;
    logic signed [11:0] sine_s;
    logic signed [17:0] diff;
    logic [23:0] abs_prod;
    logic [47:0] tenth_mult;
    logic signed [20:0] turn_full;

    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // alpha = 90 deg - |angle|; only its magnitude indexes the table
    always_comb
    begin
        mag       = in_data.angle_cdeg[15] ? 16'(-in_data.angle_cdeg)
                                           : 16'(in_data.angle_cdeg);
        alpha_neg = mag > 16'(QUARTER_TURN_CDEG);
        abs_alpha = alpha_neg ? 14'(mag - 16'(QUARTER_TURN_CDEG))
                              : 14'(16'(QUARTER_TURN_CDEG) - mag);
        m1_next   = 26'(abs_alpha) * 26'(SINE_TABLE_DEPTH - 1) + 26'(IDX_ROUND);
        seen_next = (in_data.range_mm != NO_RETURN) &&
                    (in_data.range_mm <= cfg.max_range_mm);
    end

    always_comb
    begin
        idx_mult  = 52'(m1_reg) * 52'(SINE_RECIP);
        idx_raw   = idx_mult[SINE_SHIFT +: 12];
        idx2_next = (idx_raw > LAST_ENTRY) ? SIN_IDX_W'(LAST_ENTRY) : SIN_IDX_W'(idx_raw);
    end

    always_comb
    begin
        sine_s     = neg3_reg ? -$signed({2'b00, sine3}) : $signed({2'b00, sine3});
        diff       = $signed({2'b00, scan3_reg.range_mm})
                   - $signed({4'b0000, cfg.target_gap_mm})
                   - 18'(sine_s);
        prod4_next = $signed({18'd0, cfg.gain_tenths}) * 25'(diff);
    end

    // divide by ten on the magnitude so the quotient truncates toward zero
    always_comb
    begin
        abs_prod   = prod4_reg[24] ? 24'(-prod4_reg) : 24'(prod4_reg);
        tenth_mult = 48'(abs_prod) * 48'(TENTH_RECIP);
        q5_next    = tenth_mult[TENTH_SHIFT +: 20];
    end

    always_comb
    begin
        turn_full = neg5_reg ? -$signed({1'b0, q5_reg}) : $signed({1'b0, q5_reg});
        out6_next.nearest_mm         = scan5_reg.range_mm;
        out6_next.nearest_angle_cdeg = scan5_reg.angle_cdeg;
        out6_next.obstacle_seen      = seen5_reg;
        if (!seen5_reg)
        begin
            out6_next.turn_rate_mrad_s = '0;
        end
        else if (turn_full > TURN_MAX)
        begin
            out6_next.turn_rate_mrad_s = 20'(TURN_MAX);
        end
        else if (turn_full < TURN_MIN)
        begin
            out6_next.turn_rate_mrad_s = 20'(TURN_MIN);
        end
        else
        begin
            out6_next.turn_rate_mrad_s = 20'(turn_full);
        end
    end

    nows_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .en   (v2_reg && rdy3),
        .addr (idx2_reg),
        .data (sine3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            scan1_reg <= in_data;
            seen1_reg <= seen_next;
            neg1_reg  <= alpha_neg;
            m1_reg    <= m1_next;
        end
        if (v1_reg && rdy2)
        begin
            scan2_reg <= scan1_reg;
            seen2_reg <= seen1_reg;
            neg2_reg  <= neg1_reg;
            idx2_reg  <= idx2_next;
        end
        if (v2_reg && rdy3)
        begin
            scan3_reg <= scan2_reg;
            seen3_reg <= seen2_reg;
            neg3_reg  <= neg2_reg;
        end
        if (v3_reg && rdy4)
        begin
            scan4_reg <= scan3_reg;
            seen4_reg <= seen3_reg;
            prod4_reg <= prod4_next;
        end
        if (v4_reg && rdy5)
        begin
            scan5_reg <= scan4_reg;
            seen5_reg <= seen4_reg;
            q5_reg    <= q5_next;
            neg5_reg  <= prod4_reg[24];
        end
        if (v5_reg && rdy6)
        begin
            out6_reg <= out6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out6_reg;

    a_seen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.obstacle_seen |-> out_data.nearest_mm <= cfg.max_range_mm)
        else $error("obstacle flagged beyond maximum range");

    a_no_return_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.nearest_mm == NO_RETURN |->
            out_data.nearest_angle_cdeg == 16'sd0 && !out_data.obstacle_seen)
        else $error("scan without return carries an angle or a steering flag");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && rdy2 |=> 12'(idx2_reg) <= LAST_ENTRY)
        else $error("sine index past end of table");

endmodule

@@ verif/nows_steering_checker.sv @@
// Scoreboard for the nearest-obstacle wall steering unit: follows the config port and
// both channels, predicts each scan's steering command and compares it. Uses nows_pkg.
`timescale 1ns / 1ps

module nows_steering_checker
    import nows_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_stall,
    input  nows_in_t              sample,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  nows_out_t             result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending_results
);

    localparam int BEAM_LIMIT = 1024;
    localparam int SINE_DEPTH = 1024;

    int unsigned        sine_milli [SINE_DEPTH];
    nows_cfg_t          cfg_copy;
    int                 beam_idx;
    logic [15:0]        best_range;
    logic signed [15:0] best_angle;
    nows_out_t          steering_due [$];
    nows_out_t          want;

    // 1000 * sin(i * 90deg / (depth-1)), Q30 Taylor series up to x^15
    function automatic int unsigned quarter_sine_milli(input int i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned total;
        x     = HALF_PI_Q30 * longint'(i) / (SINE_DEPTH - 1);
        x2    = (x * x) >> 30;
        term  = x;
        total = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                total -= term;
            else
                total += term;
        end
        return int'((total * 1000 + (64'd1 << 29)) >> 30);
    endfunction

    initial
    begin
        for (int i = 0; i < SINE_DEPTH; i++)
            sine_milli[i] = quarter_sine_milli(i);
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: steering check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_scan();
        beam_idx   = 0;
        best_range = NO_RETURN;
        best_angle = '0;
    endtask

    // track nearest return; on the final beam queue the expected command
    task automatic fold_sample(input nows_in_t s);
        longint    beam_pos;
        int        angle;
        int        mag;
        int        alpha;
        int        idx;
        longint    sine_v;
        longint    diff;
        longint    turn;
        logic      seen;
        nows_out_t due;
        beam_pos = longint'($signed(cfg_copy.start_angle_cdeg))
                 + longint'(cfg_copy.angle_step_cdeg) * beam_idx;
        angle = int'((beam_pos + FULL_TURN_CDEG + FULL_TURN_CDEG / 2) % FULL_TURN_CDEG)
              - FULL_TURN_CDEG / 2;
        if (s.range_mm < best_range)
        begin
            best_range = s.range_mm;
            best_angle = angle[15:0];
        end
        if (!s.last)
        begin
            if (beam_idx < BEAM_LIMIT - 1)
                beam_idx++;
        end
        else
        begin
            seen = (best_range != NO_RETURN) && (best_range <= cfg_copy.max_range_mm);
            turn = 0;
            if (seen)
            begin
                mag   = int'(best_angle);
                mag   = (mag < 0) ? -mag : mag;
                alpha = QUARTER_TURN_CDEG - mag;
                idx   = ((alpha < 0 ? -alpha : alpha) * (SINE_DEPTH - 1) + IDX_ROUND)
                      / QUARTER_TURN_CDEG;
                if (idx > SINE_DEPTH - 1)
                    idx = SINE_DEPTH - 1;
                sine_v = longint'(sine_milli[idx]);
                if (alpha < 0)
                    sine_v = -sine_v;
                diff = longint'(best_range) - longint'(cfg_copy.target_gap_mm) - sine_v;
                turn = longint'(cfg_copy.gain_tenths) * diff / 10;
                if (turn > longint'(TURN_MAX))
                    turn = longint'(TURN_MAX);
                if (turn < longint'(TURN_MIN))
                    turn = longint'(TURN_MIN);
            end
            due.turn_rate_mrad_s   = turn[19:0];
            due.nearest_mm         = best_range;
            due.nearest_angle_cdeg = best_angle;
            due.obstacle_seen      = seen;
            steering_due.push_back(due);
            clear_scan();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_copy = '{START_ANGLE_RST, ANGLE_STEP_RST, MAX_RANGE_RST,
                         TARGET_GAP_RST, GAIN_RST};
            clear_scan();
            steering_due.delete();
            fail_count      = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_START_ANGLE: cfg_copy.start_angle_cdeg = cfg_data[15:0];
                    CFG_ANGLE_STEP:  cfg_copy.angle_step_cdeg  = cfg_data[11:0];
                    CFG_MAX_RANGE:   cfg_copy.max_range_mm     = cfg_data[15:0];
                    CFG_TARGET_GAP:  cfg_copy.target_gap_mm    = cfg_data[13:0];
                    CFG_GAIN:        cfg_copy.gain_tenths      = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
                fold_sample(sample);
            if (result_valid && !result_stall)
            begin
                if (steering_due.size() == 0)
                    report_mismatch($sformatf("result transfer with no scan pending (turn %0d)",
                                              $signed(result.turn_rate_mrad_s)));
                else
                begin
                    want = steering_due.pop_front();
                    if (result.turn_rate_mrad_s !== want.turn_rate_mrad_s)
                        report_mismatch($sformatf("turn_rate_mrad_s got %0d expected %0d",
                                                  $signed(result.turn_rate_mrad_s),
                                                  $signed(want.turn_rate_mrad_s)));
                    if (result.nearest_mm !== want.nearest_mm)
                        report_mismatch($sformatf("nearest_mm got %0d expected %0d",
                                                  result.nearest_mm, want.nearest_mm));
                    if (result.nearest_angle_cdeg !== want.nearest_angle_cdeg)
                        report_mismatch($sformatf("nearest_angle_cdeg got %0d expected %0d",
                                                  $signed(result.nearest_angle_cdeg),
                                                  $signed(want.nearest_angle_cdeg)));
                    if (result.obstacle_seen !== want.obstacle_seen)
                        report_mismatch($sformatf("obstacle_seen got %0b expected %0b",
                                                  result.obstacle_seen, want.obstacle_seen));
                end
            end
            pending_results = steering_due.size();
        end
    end

endmodule

@@ verif/nearest_obstacle_wall_steering_unit_tb.sv @@
// Testbench top for the nearest-obstacle wall steering unit: clock, reset, scan and
// config stimulus, verdict. Depends on nows_pkg, the unit and nows_steering_checker.
`timescale 1ns / 1ps

module nearest_obstacle_wall_steering_unit_tb;
    import nows_pkg::*;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    nows_in_t              sample       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    nows_out_t             result;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_START_ANGLE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    int                    fail_count;
    int                    pending_results;

    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    int          samples_sent    = 0;
    logic [15:0] max_range_set   = MAX_RANGE_RST;

    nearest_obstacle_wall_steering_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    nows_steering_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        result_stall = rst_n && ($urandom_range(99) < stall_pct);

    initial
    begin
        #10_000_000;
        $display("nearest_obstacle_wall_steering_unit_tb failed");
        $finish;
    end

    task automatic push_sample(input logic [15:0] range_mm, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_valid = 1'b1;
        sample       = '{range_mm: range_mm, last: last};
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic hold_for_results();
        sample_valid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // quiet the block before touching registers; angle and steering pipes drain
    task automatic settle();
        hold_for_results();
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_write = 1'b1;
        @(negedge clk);
    endtask

    // bits above each register's width carry junk and must be dropped
    task automatic load_config(input logic [15:0] start_cdeg, input logic [11:0] step_cdeg,
                               input logic [15:0] max_mm, input logic [13:0] gap_mm,
                               input logic [6:0] gain);
        logic [15:0] junk;
        junk = 16'($urandom);
        settle();
        write_reg(CFG_START_ANGLE, start_cdeg);
        write_reg(CFG_ANGLE_STEP, {junk[15:12], step_cdeg});
        write_reg(CFG_MAX_RANGE, max_mm);
        write_reg(CFG_TARGET_GAP, {junk[1:0], gap_mm});
        write_reg(CFG_GAIN, {junk[11:3], gain});
        // unused indexes above the gain register
        for (int k = 1; k <= 3; k++)
            write_reg(CFG_GAIN + CFG_IDX_W'(k), 16'($urandom));
        cfg_write = 1'b0;
        max_range_set = max_mm;
    endtask

    task automatic load_random_config();
        logic [15:0] start_cdeg;
        logic [11:0] step_cdeg;
        logic [15:0] max_mm;
        logic [13:0] gap_mm;
        logic [6:0]  gain;
        case ($urandom_range(5))
            0:       start_cdeg = -16'sd18000;
            1:       start_cdeg = 16'sd18000;
            2:       start_cdeg = 16'h8000;
            3:       start_cdeg = 16'h7FFF;
            default: start_cdeg = 16'($signed($urandom_range(36000)) - 18000);
        endcase
        case ($urandom_range(5))
            0:       step_cdeg = 12'd0;
            1:       step_cdeg = 12'd3600;
            2:       step_cdeg = 12'hFFF;
            default: step_cdeg = 12'($urandom_range(3600));
        endcase
        case ($urandom_range(5))
            0:       max_mm = 16'd0;
            1:       max_mm = 16'd65534;
            2:       max_mm = 16'hFFFF;
            default: max_mm = 16'($urandom_range(8000));
        endcase
        case ($urandom_range(5))
            0:       gap_mm = 14'd0;
            1:       gap_mm = 14'd10000;
            2:       gap_mm = 14'h3FFF;
            default: gap_mm = 14'($urandom_range(10000));
        endcase
        case ($urandom_range(5))
            0:       gain = 7'd0;
            1:       gain = 7'd100;
            2:       gain = 7'h7F;
            default: gain = 7'($urandom_range(100));
        endcase
        load_config(start_cdeg, step_cdeg, max_mm, gap_mm, gain);
    endtask

    function automatic logic [15:0] pick_range();
        int top;
        top = 2 * int'(max_range_set) + 10;
        if (top > 65535)
            top = 65535;
        case ($urandom_range(7))
            0:       return NO_RETURN;
            1:       return 16'($urandom);
            2:       return 16'(int'(max_range_set) + int'($urandom_range(6)) - 3);
            3:       return 16'($urandom_range(255));
            default: return 16'($urandom_range(top));
        endcase
    endfunction

    task automatic play_scan(input int beams);
        for (int b = 0; b < beams; b++)
            push_sample(pick_range(), b == beams - 1);
    endtask

    initial
    begin
        int scan_no;
        int goal;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset config: no return, zero range, first of equal minima, range limit
        push_sample(NO_RETURN, 1'b0);
        push_sample(NO_RETURN, 1'b1);
        push_sample(16'd0, 1'b1);
        push_sample(16'd500, 1'b0);
        push_sample(16'd300, 1'b0);
        push_sample(16'd300, 1'b0);
        push_sample(16'd900, 1'b1);
        push_sample(16'd3501, 1'b0);
        push_sample(16'd3600, 1'b1);
        push_sample(16'd3500, 1'b1);

        // angle wrap past +180 deg and positive saturation
        load_config(16'sd17000, 12'd3600, 16'd65534, 14'd0, 7'd127);
        push_sample(16'd900, 1'b0);
        push_sample(16'd800, 1'b0);
        push_sample(16'd700, 1'b1);
        push_sample(16'd65534, 1'b1);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b1);

        // raw extremes of every register; zero range limit
        load_config(16'h8000, 12'hFFF, 16'd0, 14'h3FFF, 7'h7F);
        push_sample(16'd0, 1'b1);
        push_sample(16'd1, 1'b0);
        push_sample(NO_RETURN, 1'b1);

        for (int mode = 0; mode < 4; mode++)
        begin
            sender_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 61 : 21) : 0;
            stall_pct       = (mode == 2 || mode == 3) ? ((mode == 2) ? 61 : 21) : 0;
            for (int sub = 0; sub < 2; sub++)
            begin
                load_random_config();
                goal    = samples_sent + 64;
                scan_no = 0;
                while (samples_sent < goal)
                begin
                    if (scan_no % 25 == 12 || $urandom_range(29) == 0)
                        hold_for_results();
                    case ($urandom_range(9))
                        0:       play_scan(1);
                        1:       play_scan($urandom_range(60, 21));
                        default: play_scan($urandom_range(20, 2));
                    endcase
                    scan_no++;
                end
            end
        end

        hold_for_results();
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("nearest_obstacle_wall_steering_unit_tb passed");
        else
            $display("nearest_obstacle_wall_steering_unit_tb failed");
        $finish;
    end

endmodule
